// File: rtl/single_float_adder_core_defines.svh
// ----------------------------------------------------------------------------
// single_float_adder_core_defines.svh
// Assertion macros shared by the float adder RTL.
// ----------------------------------------------------------------------------
`ifndef SINGLE_FLOAT_ADDER_CORE_DEFINES_SVH
`define SINGLE_FLOAT_ADDER_CORE_DEFINES_SVH

// Implication checked on every edge outside of reset.
`define SFA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m failed");

`endif

// File: rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg
// Widths and helper functions for the single-precision adder.
// ----------------------------------------------------------------------------
package sfa_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned ExpWidth  = 8;
   localparam int unsigned FracWidth = 23;
   // hidden one, fraction and two guard bits, plus one carry bit
   localparam int unsigned SigWidth  = 27;
   localparam int unsigned LzWidth   = 5;

   typedef logic [WordWidth-1:0] word_type;
   typedef logic [SigWidth-1:0]  sig_type;
   typedef logic [LzWidth-1:0]   lz_type;

   // leading zeros of a nonzero 27-bit significand, counted from bit 26
   function automatic lz_type lead_zeros(input sig_type v);
      lz_type n;
      n = '0;
      for (int i = 0; i < SigWidth; i++) begin
         if (v[i]) begin
            n = LzWidth'(SigWidth - 1 - i);
         end
      end
      return n;
   endfunction

endpackage

// File: rtl/sfa_datapath.sv
// ----------------------------------------------------------------------------
// sfa_datapath
// Align, add or subtract, normalize and round one operand pair.
// ----------------------------------------------------------------------------
module sfa_datapath (
   input  sfa_pkg::word_type operand_a,
   input  sfa_pkg::word_type operand_b,
   output sfa_pkg::word_type sum
);

   logic                        a_big;
   sfa_pkg::word_type           big_op;
   sfa_pkg::word_type           small_op;
   logic [sfa_pkg::ExpWidth-1:0] exp_big;
   logic [sfa_pkg::ExpWidth-1:0] exp_small;
   logic [sfa_pkg::ExpWidth-1:0] exp_diff;
   sfa_pkg::sig_type            wide_big;
   sfa_pkg::sig_type            aligned;
   sfa_pkg::sig_type            acc;
   sfa_pkg::lz_type             lz;
   sfa_pkg::sig_type            norm;
   logic [9:0]                  expo;
   logic [sfa_pkg::ExpWidth-1:0] expf;
   sfa_pkg::word_type           packed_sum;
   logic                        pass_big;

   // pick the operand with the larger magnitude; ties go to b
   assign a_big     = operand_a[30:0] > operand_b[30:0];
   assign big_op    = a_big ? operand_a : operand_b;
   assign small_op  = a_big ? operand_b : operand_a;
   assign exp_big   = big_op[30:23];
   assign exp_small = small_op[30:23];
   assign exp_diff  = exp_big - exp_small;

   // significands with hidden one at bit 25 and two guard bits
   assign wide_big = {2'b01, big_op[22:0], 2'b00};
   assign aligned  = {2'b01, small_op[22:0], 2'b00} >> exp_diff[4:0];

   assign acc = (operand_a[31] ^ operand_b[31]) ? (wide_big - aligned)
                                                : (wide_big + aligned);

   // normalize so the leading one lands on bit 26
   assign lz   = sfa_pkg::lead_zeros(acc);
   assign norm = acc << lz;
   assign expo = {2'b00, exp_big} + 10'd1 - {5'b00000, lz};
   // negative or 256 clears the exponent field
   assign expf = expo[8] ? '0 : expo[7:0];

   // round half-up on the first dropped bit, carry may reach sign
   assign packed_sum = {big_op[31], expf, norm[25:3]} + {31'b0, norm[2]};

   assign pass_big = (exp_small == '0) || (exp_diff[7:5] != 3'b000);

   always_comb begin
      if (pass_big) begin
         sum = big_op;
      end else if (acc == '0) begin
         sum = {big_op[31], 31'b0};
      end else begin
         sum = packed_sum;
      end
   end

endmodule

// File: rtl/single_float_adder_core.sv
// ----------------------------------------------------------------------------
// single_float_adder_core
// Simplified single-precision adder with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel carries req_operand_a and req_operand_b, two single
//   precision bit patterns, one pair per beat. The response channel returns
//   rsp_sum, one beat per request, in order.
//   The operands are captured in an input register, the sum is computed by
//   one pass of align/add/normalize/round logic and captured in the result
//   register. Throughput is one beat per cycle while rsp_ready stays high;
//   the single combinational pass between the two registers sets that figure.
//   When the receiver stalls, the result register holds and the input
//   register holds too once full, so at most two beats are buffered; ready
//   drops only when both are occupied and rsp_ready is low.
//   Synchronous reset empties both registers; no clearing pass is needed.
//   NaN, infinity and denormals get no special handling.
// ----------------------------------------------------------------------------
`include "single_float_adder_core_defines.svh"

module single_float_adder_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sfa_pkg::word_type req_operand_a,
   input  sfa_pkg::word_type req_operand_b,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sfa_pkg::word_type rsp_sum
);

   logic              in_valid_ff, in_valid_in;
   sfa_pkg::word_type op_a_ff, op_b_ff;
   logic              out_valid_ff, out_valid_in;
   sfa_pkg::word_type sum_ff;
   sfa_pkg::word_type sum_comb;
   logic              advance;
   logic              take;

   // stage moves when the result register is free or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   sfa_datapath u_datapath (
      .operand_a (op_a_ff),
      .operand_b (op_b_ff),
      .sum       (sum_comb)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         op_a_ff <= req_operand_a;
         op_b_ff <= req_operand_b;
      end
      if (advance && in_valid_ff) begin
         sum_ff <= sum_comb;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_sum   = sum_ff;

   // accepted beat always lands in the input register
   `SFA_ASSERT(a_take_fills, clock, reset, take |=> in_valid_ff)
   // a held input beat is not lost while the output stalls
   `SFA_ASSERT(a_hold_in, clock, reset,
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(op_a_ff) && $stable(op_b_ff)))
   // a drained result with nothing behind it empties the output
   `SFA_ASSERT(a_drain, clock, reset,
      (rsp_valid && rsp_ready && !in_valid_ff) |=> !rsp_valid)
   // input register full moves into the output when it is free
   `SFA_ASSERT(a_move, clock, reset, (in_valid_ff && advance) |=> rsp_valid)

endmodule
